// File: sv/eis_shift_multiply_divide_unit_core_assert.svh
// assertion macros for the extended arithmetic unit
// no dependencies; included by the top level
`ifndef EIS_SHIFT_MULTIPLY_DIVIDE_UNIT_CORE_ASSERT_SVH
`define EIS_SHIFT_MULTIPLY_DIVIDE_UNIT_CORE_ASSERT_SVH
`ifndef NO_ASSERTIONS
`define EIS_ASSERT(label, clk, rstn, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);
`define EIS_ASSERT_RST(label, clk, prop, msg) \
    label: assert property (@(posedge clk) prop) else $error(msg);
`else
`define EIS_ASSERT(label, clk, rstn, prop, msg)
`define EIS_ASSERT_RST(label, clk, prop, msg)
`endif
`endif

// File: sv/eis_pkg.sv
// shared types and constants for the extended arithmetic unit
// no dependencies
package eis_pkg;

    localparam logic [2:0] OP_ASH  = 3'd0;
    localparam logic [2:0] OP_ASHC = 3'd1;
    localparam logic [2:0] OP_MUL  = 3'd2;
    localparam logic [2:0] OP_DIV  = 3'd3;
    localparam logic [2:0] OP_XOR  = 3'd4;

    localparam int FL_N = 3;
    localparam int FL_Z = 2;
    localparam int FL_V = 1;
    localparam int FL_C = 0;

    typedef struct packed {
        logic [2:0]  op;
        logic [15:0] reg_value;
        logic [15:0] pair_value;
        logic [15:0] operand;
        logic [3:0]  flags_in;
    } in_item_t;

    typedef struct packed {
        logic [15:0] result_hi;
        logic [15:0] result_lo;
        logic        write_reg;
        logic        write_pair;
        logic        write_dest;
        logic [3:0]  flags_out;
    } out_item_t;

    // controller to datapath
    typedef struct packed {
        logic load;
        logic step;
        logic finish;
    } dp_cmd_t;

    // datapath to controller
    typedef struct packed {
        logic done;
    } dp_stat_t;

endpackage

// File: sv/eis_ctrl.sv
// controller for the extended arithmetic unit: request handshake and sequencing
// depends on eis_pkg
module eis_ctrl (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_valid,
    output logic               s_ready,
    output logic               m_valid,
    input  logic               m_ready,
    output eis_pkg::dp_cmd_t   cmd,
    input  eis_pkg::dp_stat_t  stat
);

    typedef enum logic [1:0] {ST_IDLE, ST_RUN, ST_FIN} state_t;

    state_t state_reg;
    logic   m_valid_reg;
    logic   out_free;

    // accept whenever idle; the result register is only overwritten once free
    assign out_free   = !m_valid_reg || m_ready;
    assign s_ready    = (state_reg == ST_IDLE);
    assign m_valid    = m_valid_reg;
    assign cmd.load   = s_valid && s_ready;
    assign cmd.step   = (state_reg == ST_RUN);
    assign cmd.finish = (state_reg == ST_FIN) && out_free;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            m_valid_reg <= 1'b0;
        end else begin
            // result slot: filled at finish, emptied when taken
            if (cmd.finish) m_valid_reg <= 1'b1;
            else if (m_ready) m_valid_reg <= 1'b0;
            case (state_reg)
                ST_IDLE: begin
                    if (s_valid && s_ready) state_reg <= ST_RUN;
                end
                ST_RUN: begin
                    if (stat.done) state_reg <= ST_FIN;
                end
                ST_FIN: begin
                    if (out_free) state_reg <= ST_IDLE;
                end
                default: state_reg <= ST_IDLE;
            endcase
        end
    end

endmodule

// File: sv/eis_dpath.sv
// datapath: one-bit-per-cycle shifter, shift-add multiplier, restoring divider
// depends on eis_pkg
module eis_dpath (
    input  logic                aclk,
    input  eis_pkg::in_item_t   s_item,
    input  eis_pkg::dp_cmd_t    cmd,
    output eis_pkg::dp_stat_t   stat,
    output eis_pkg::out_item_t  m_item
);

    logic [2:0]  op_reg;
    logic [3:0]  flg_reg;
    logic [31:0] acc_reg, acc_next;     // shift value / product / remainder
    logic [31:0] aux_reg, aux_next;     // original value / quotient
    logic [15:0] mag_reg;               // |divisor| or multiplicand
    logic [5:0]  cnt_reg, cnt_next;
    logic        dir_reg;               // shift right
    logic        cbit_reg, cbit_next;
    logic        qneg_reg, rneg_reg;
    logic        z_reg;                 // zero amount / zero divisor
    eis_pkg::out_item_t m_item_reg, res;

    logic [15:0] a16, b16;
    logic [31:0] dvd_abs;
    logic [32:0] trial;
    logic [31:0] q_s, r_s;
    logic [5:0]  amt;

    assign a16 = s_item.reg_value[15] ? (16'd0 - s_item.reg_value) : s_item.reg_value;
    assign b16 = s_item.operand[15] ? (16'd0 - s_item.operand) : s_item.operand;
    assign dvd_abs = s_item.reg_value[15] ?
        (32'd0 - {s_item.reg_value, s_item.pair_value}) : {s_item.reg_value, s_item.pair_value};
    assign amt = s_item.operand[5:0];
    assign stat.done = (cnt_reg == 6'd0);
    assign m_item = m_item_reg;

    // one iteration per cycle
    always_comb begin
        acc_next  = acc_reg;
        aux_next  = aux_reg;
        cbit_next = cbit_reg;
        cnt_next  = (cnt_reg == 6'd0) ? cnt_reg : cnt_reg - 6'd1;
        trial     = 33'd0;
        if (cnt_reg != 6'd0) begin
            case (op_reg)
                eis_pkg::OP_ASH, eis_pkg::OP_ASHC: begin
                    if (dir_reg) begin
                        cbit_next = acc_reg[0];
                        acc_next  = (op_reg == eis_pkg::OP_ASH) ?
                            {16'd0, acc_reg[15], acc_reg[15:1]} : {acc_reg[31], acc_reg[31:1]};
                    end else begin
                        cbit_next = (op_reg == eis_pkg::OP_ASH) ? acc_reg[15] : acc_reg[31];
                        acc_next  = (op_reg == eis_pkg::OP_ASH) ?
                            {16'd0, acc_reg[14:0], 1'b0} : {acc_reg[30:0], 1'b0};
                    end
                end
                eis_pkg::OP_MUL: begin
                    // aux holds multiplier bits, acc the product
                    acc_next = {acc_reg[30:0], 1'b0} +
                        (aux_reg[15] ? {16'd0, mag_reg} : 32'd0);
                    aux_next = {aux_reg[31:16], aux_reg[14:0], 1'b0};
                end
                eis_pkg::OP_DIV: begin
                    // restoring divide: acc remainder, aux dividend/quotient
                    trial = {acc_reg, aux_reg[31]} - {17'd0, mag_reg};
                    if (!trial[32]) begin
                        acc_next = trial[31:0];
                        aux_next = {aux_reg[30:0], 1'b1};
                    end else begin
                        acc_next = {acc_reg[30:0], aux_reg[31]};
                        aux_next = {aux_reg[30:0], 1'b0};
                    end
                end
                default: ;
            endcase
        end
    end

    // result formatting
    always_comb begin
        res   = '0;
        q_s   = qneg_reg ? (32'd0 - aux_reg) : aux_reg;
        r_s   = rneg_reg ? (32'd0 - acc_reg) : acc_reg;
        res.flags_out = flg_reg;
        case (op_reg)
            eis_pkg::OP_ASH: begin
                res.flags_out[eis_pkg::FL_N] = acc_reg[15];
                res.flags_out[eis_pkg::FL_Z] = (acc_reg[15:0] == 16'd0);
                res.flags_out[eis_pkg::FL_V] = acc_reg[15] ^ aux_reg[15];
                if (!z_reg) begin
                    res.flags_out[eis_pkg::FL_C] = cbit_reg;
                    res.result_hi = acc_reg[15:0];
                    res.write_reg = 1'b1;
                end
            end
            eis_pkg::OP_ASHC: begin
                res.flags_out[eis_pkg::FL_N] = acc_reg[31];
                res.flags_out[eis_pkg::FL_Z] = (acc_reg == 32'd0);
                res.flags_out[eis_pkg::FL_V] = acc_reg[31] ^ aux_reg[31];
                if (!z_reg) begin
                    res.flags_out[eis_pkg::FL_C] = cbit_reg;
                    res.result_hi  = acc_reg[31:16];
                    res.result_lo  = acc_reg[15:0];
                    res.write_reg  = 1'b1;
                    res.write_pair = 1'b1;
                end
            end
            eis_pkg::OP_MUL: begin
                res.result_hi  = r_s[31:16];
                res.result_lo  = r_s[15:0];
                res.write_reg  = 1'b1;
                res.write_pair = 1'b1;
                res.flags_out  = {r_s[31], (r_s == 32'd0), 2'b00};
            end
            eis_pkg::OP_DIV: begin
                if (z_reg) begin
                    res.flags_out[eis_pkg::FL_V] = 1'b1;
                    res.flags_out[eis_pkg::FL_C] = 1'b1;
                end else begin
                    res.result_hi  = q_s[15:0];
                    res.result_lo  = r_s[15:0];
                    res.write_reg  = 1'b1;
                    res.write_pair = 1'b1;
                    // sign from the magnitude, as +2^31 does not fit 32 bits
                    res.flags_out[eis_pkg::FL_N] = qneg_reg && (aux_reg != 32'd0);
                    res.flags_out[eis_pkg::FL_Z] = (aux_reg == 32'd0);
                    res.flags_out[eis_pkg::FL_V] =
                        (q_s[31:15] != 17'd0) && (q_s[31:15] != 17'h1ffff);
                    res.flags_out[eis_pkg::FL_C] = 1'b0;
                end
            end
            eis_pkg::OP_XOR: begin
                res.result_hi  = acc_reg[15:0];
                res.write_dest = 1'b1;
                res.flags_out[eis_pkg::FL_N] = acc_reg[15];
                res.flags_out[eis_pkg::FL_Z] = (acc_reg[15:0] == 16'd0);
                res.flags_out[eis_pkg::FL_V] = 1'b0;
            end
            default: ;
        endcase
    end

    // operand load and iteration registers
    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            op_reg   <= s_item.op;
            flg_reg  <= s_item.flags_in;
            cbit_reg <= s_item.flags_in[eis_pkg::FL_C];
            dir_reg  <= amt[5];
            z_reg    <= 1'b0;
            qneg_reg <= 1'b0;
            rneg_reg <= 1'b0;
            mag_reg  <= 16'd0;
            cnt_reg  <= 6'd0;
            acc_reg  <= 32'd0;
            aux_reg  <= 32'd0;
            case (s_item.op)
                eis_pkg::OP_ASH, eis_pkg::OP_ASHC: begin
                    acc_reg <= (s_item.op == eis_pkg::OP_ASH) ? {16'd0, s_item.reg_value} :
                        {s_item.reg_value, s_item.pair_value};
                    aux_reg <= (s_item.op == eis_pkg::OP_ASH) ? {16'd0, s_item.reg_value} :
                        {s_item.reg_value, s_item.pair_value};
                    z_reg   <= (amt == 6'd0);
                    cnt_reg <= amt[5] ? (6'd0 - amt) : amt;
                end
                eis_pkg::OP_MUL: begin
                    mag_reg  <= a16;
                    aux_reg  <= {16'd0, b16};
                    rneg_reg <= s_item.reg_value[15] ^ s_item.operand[15];
                    cnt_reg  <= 6'd16;
                end
                eis_pkg::OP_DIV: begin
                    mag_reg  <= b16;
                    aux_reg  <= dvd_abs;
                    z_reg    <= (s_item.operand == 16'd0);
                    qneg_reg <= s_item.reg_value[15] ^ s_item.operand[15];
                    rneg_reg <= s_item.reg_value[15];
                    cnt_reg  <= (s_item.operand == 16'd0) ? 6'd0 : 6'd32;
                end
                eis_pkg::OP_XOR: begin
                    acc_reg <= {16'd0, s_item.reg_value ^ s_item.operand};
                end
                default: ;
            endcase
        end else if (cmd.step) begin
            acc_reg  <= acc_next;
            aux_reg  <= aux_next;
            cbit_reg <= cbit_next;
            cnt_reg  <= cnt_next;
        end
        if (cmd.finish) m_item_reg <= res;
    end

endmodule

// File: sv/eis_shift_multiply_divide_unit_core.sv
// Extended arithmetic unit: arithmetic shift, combined pair shift, signed multiply,
// signed divide and exclusive or. One request is processed at a time. With N the
// iterations of the shared shift/add/subtract unit (the shift count, 0..32, for
// shifts, 16 for multiply, 32 for divide, none for exclusive or or a zero divisor),
// the result is registered after the N iterations, and the next request is accepted
// only once the previous result is in the result register. The result register holds
// the last result until taken while the unit accepts and computes the next request;
// that second result waits in the unit, blocking further requests, until the
// register is free.
module eis_shift_multiply_divide_unit_core (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_valid,
    output logic                s_ready,
    input  eis_pkg::in_item_t   s_item,
    output logic                m_valid,
    input  logic                m_ready,
    output eis_pkg::out_item_t  m_item
);

`include "eis_shift_multiply_divide_unit_core_assert.svh"

    eis_pkg::dp_cmd_t  cmd;
    eis_pkg::dp_stat_t stat;

    eis_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .cmd     (cmd),
        .stat    (stat)
    );

    eis_dpath u_dpath (
        .aclk   (aclk),
        .s_item (s_item),
        .cmd    (cmd),
        .stat   (stat),
        .m_item (m_item)
    );

    // checks
    `EIS_ASSERT(a_no_accept_busy, aclk, aresetn, cmd.step |-> !s_ready, "accept while busy")
    `EIS_ASSERT(a_finish_valid, aclk, aresetn, cmd.finish |=> m_valid, "result not shown")
    `EIS_ASSERT(a_load_runs, aclk, aresetn, cmd.load |=> cmd.step, "load not followed by run")
    `EIS_ASSERT_RST(a_reset_idle, aclk, !aresetn |=> !m_valid, "valid out of reset")

endmodule

// File: tb/sv/eis_shift_multiply_divide_unit_core_checker.sv
// checker for the extended arithmetic unit: predicts each result and compares
// depends on eis_pkg for the request and result types
module eis_shift_multiply_divide_unit_core_checker (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_valid,
    input  logic                s_ready,
    input  eis_pkg::in_item_t   s_item,
    input  logic                m_valid,
    input  logic                m_ready,
    input  eis_pkg::out_item_t  m_item,
    output int                  fail_count,
    output int                  pending_count,
    output int                  result_count
);

    eis_pkg::out_item_t expected_results[$];

    // shift a value with sign bit at position top by a six-bit count
    function automatic logic [31:0] arith_shift(input logic [31:0] v, input int top,
                                                input logic [5:0] amt,
                                                inout logic [3:0] fl);
        logic [31:0] mask;
        logic        s;
        int          n;
        mask = (top == 31) ? 32'hFFFF_FFFF : 32'h0000_FFFF;
        s = v[top];
        if (amt[5]) begin
            n = 64 - amt;
            for (int i = 0; i < n; i++) begin
                fl[eis_pkg::FL_C] = v[0];
                v = (v >> 1);
                v[top] = s;
            end
        end else begin
            n = amt[4:0];
            for (int i = 0; i < n; i++) begin
                fl[eis_pkg::FL_C] = v[top];
                v = (v << 1) & mask;
            end
        end
        return v;
    endfunction

    // compute the result of one instruction
    function automatic eis_pkg::out_item_t execute_instruction(input eis_pkg::in_item_t q);
        eis_pkg::out_item_t r;
        logic [31:0] v, sh;
        logic [3:0]  fl;
        int          top;
        logic signed [31:0] prod;
        longint      dvd, dvs, quo, rem;
        r = '0;
        fl = q.flags_in;
        case (q.op)
            eis_pkg::OP_ASH, eis_pkg::OP_ASHC: begin
                top = (q.op == eis_pkg::OP_ASH) ? 15 : 31;
                v = (q.op == eis_pkg::OP_ASH) ? {16'h0, q.reg_value}
                                              : {q.reg_value, q.pair_value};
                sh = v;
                if (q.operand[5:0] != 0) begin
                    sh = arith_shift(v, top, q.operand[5:0], fl);
                    if (q.op == eis_pkg::OP_ASH) begin
                        r.result_hi = sh[15:0];
                        r.write_reg = 1'b1;
                    end else begin
                        r.result_hi = sh[31:16];
                        r.result_lo = sh[15:0];
                        r.write_reg = 1'b1;
                        r.write_pair = 1'b1;
                    end
                end
                fl[eis_pkg::FL_N] = sh[top];
                fl[eis_pkg::FL_Z] = (sh == 0);
                fl[eis_pkg::FL_V] = sh[top] ^ v[top];
            end
            eis_pkg::OP_MUL: begin
                prod = $signed(q.reg_value) * $signed(q.operand);
                r.result_hi = prod[31:16];
                r.result_lo = prod[15:0];
                r.write_reg = 1'b1;
                r.write_pair = 1'b1;
                fl = '0;
                fl[eis_pkg::FL_Z] = (prod == 0);
                fl[eis_pkg::FL_N] = prod[31];
            end
            eis_pkg::OP_DIV: begin
                if (q.operand == 0) begin
                    fl[eis_pkg::FL_C] = 1'b1;
                    fl[eis_pkg::FL_V] = 1'b1;
                end else begin
                    dvd = longint'($signed({q.reg_value, q.pair_value}));
                    dvs = longint'($signed(q.operand));
                    quo = dvd / dvs;
                    rem = dvd % dvs;
                    fl = '0;
                    fl[eis_pkg::FL_Z] = (quo == 0);
                    fl[eis_pkg::FL_V] = (quo > 32767 || quo < -32768);
                    fl[eis_pkg::FL_N] = (quo < 0);
                    r.result_hi = quo[15:0];
                    r.result_lo = rem[15:0];
                    r.write_reg = 1'b1;
                    r.write_pair = 1'b1;
                end
            end
            eis_pkg::OP_XOR: begin
                r.result_hi = q.reg_value ^ q.operand;
                r.write_dest = 1'b1;
                fl[eis_pkg::FL_N] = r.result_hi[15];
                fl[eis_pkg::FL_Z] = (r.result_hi == 0);
                fl[eis_pkg::FL_V] = 1'b0;
            end
            default: ;
        endcase
        r.flags_out = fl;
        return r;
    endfunction

    assign pending_count = expected_results.size();

    // predict on each accepted request, compare on each accepted result
    always @(posedge aclk) begin
        eis_pkg::out_item_t e;
        if (!aresetn) begin
            fail_count <= 0;
            result_count <= 0;
        end else begin
            if (s_valid && s_ready)
                expected_results.push_back(execute_instruction(s_item));
            if (m_valid && m_ready) begin
                result_count <= result_count + 1;
                if (expected_results.size() == 0) begin
                    $display("%0t: unexpected result %h", $time, m_item);
                    fail_count <= fail_count + 1;
                end else begin
                    e = expected_results.pop_front();
                    if (e.result_hi !== m_item.result_hi || e.result_lo !== m_item.result_lo
                        || e.write_reg !== m_item.write_reg
                        || e.write_pair !== m_item.write_pair
                        || e.write_dest !== m_item.write_dest
                        || e.flags_out !== m_item.flags_out) begin
                        $display({"%0t: mismatch hi %h/%h lo %h/%h wr %b/%b wp %b/%b",
                                  " wd %b/%b fl %h/%h"},
                                 $time, e.result_hi, m_item.result_hi, e.result_lo,
                                 m_item.result_lo, e.write_reg, m_item.write_reg,
                                 e.write_pair, m_item.write_pair, e.write_dest,
                                 m_item.write_dest, e.flags_out, m_item.flags_out);
                        fail_count <= fail_count + 1;
                    end
                end
            end
        end
    end
endmodule

// File: tb/sv/eis_shift_multiply_divide_unit_core_tb.sv
// testbench top for the extended arithmetic unit: stimulus, stalls and verdict
// depends on eis_pkg, the unit and its checker
module eis_shift_multiply_divide_unit_core_tb;

    localparam int WATCHDOG_LIMIT = 5000;

    logic      aclk = 1'b0;
    logic      aresetn = 1'b0;
    logic      s_valid = 1'b0;
    logic      s_ready;
    eis_pkg::in_item_t  s_item = '0;
    logic      m_valid;
    logic      m_ready = 1'b0;
    eis_pkg::out_item_t m_item;
    int        fail_count, pending_count, result_count;
    int        idle_cycles = 0;
    int        sent = 0;
    bit        long_hold = 1'b0;
    bit        stim_done = 1'b0;

    always begin
        #1 aclk = 1'b1;
        #1 aclk = 1'b0;
    end

    eis_shift_multiply_divide_unit_core uut (
        .aclk(aclk), .aresetn(aresetn), .s_valid(s_valid), .s_ready(s_ready),
        .s_item(s_item), .m_valid(m_valid), .m_ready(m_ready), .m_item(m_item)
    );

    eis_shift_multiply_divide_unit_core_checker chk (
        .aclk(aclk), .aresetn(aresetn), .s_valid(s_valid), .s_ready(s_ready),
        .s_item(s_item), .m_valid(m_valid), .m_ready(m_ready), .m_item(m_item),
        .fail_count(fail_count), .pending_count(pending_count),
        .result_count(result_count)
    );

    // offer one request at a falling edge and hold it until accepted
    task automatic send_request(input logic [2:0] op, input logic [15:0] rv,
                                input logic [15:0] pv, input logic [15:0] opd,
                                input logic [3:0] fl);
        s_item = '{op: op, reg_value: rv, pair_value: pv, operand: opd, flags_in: fl};
        s_valid = 1'b1;
        // ready comes from registers only, so it is stable here
        while (!s_ready) @(negedge aclk);
        @(negedge aclk);
        sent++;
        s_valid = 1'b0;
    endtask

    // random request, mostly legal ops and interesting operands
    task automatic send_random;
        logic [2:0]  op;
        logic [15:0] opd;
        op = ($urandom_range(0, 19) == 0) ? 3'($urandom_range(5, 7))
                                         : 3'($urandom_range(0, 4));
        opd = 16'($urandom);
        if ((op == eis_pkg::OP_DIV) && ($urandom_range(0, 15) == 0)) opd = 16'h0;
        if ((op == eis_pkg::OP_DIV) && ($urandom_range(0, 3) == 0))
            opd = 16'($urandom_range(1, 15));
        if ((op == eis_pkg::OP_DIV) && ($urandom_range(0, 7) == 0)) opd = 16'hFFFF;
        send_request(op, 16'($urandom), 16'($urandom), opd, 4'($urandom));
    endtask

    // receiver stall pattern, with a long hold-off when asked
    always @(negedge aclk) begin
        if (long_hold)
            m_ready <= 1'b0;
        else if (stim_done)
            m_ready <= 1'b1;
        else
            m_ready <= ($urandom_range(0, 3) != 0);
    end

    // watchdog on cycles without any accepted request or result
    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready) || !aresetn)
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("[eis_shift_multiply_divide_unit_core] ERROR");
            $finish;
        end
    end

    initial begin
        int burst;
        repeat (6) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // directed: extremes of shifts, multiply, divide and xor, and two undefined opcodes
        send_request(eis_pkg::OP_ASH, 16'h8001, 16'h0, 16'h0000, 4'hF);
        send_request(eis_pkg::OP_ASH, 16'h4001, 16'h0, 16'h0001, 4'h0);
        send_request(eis_pkg::OP_ASH, 16'h8001, 16'h0, 16'h003F, 4'h0);
        send_request(eis_pkg::OP_ASH, 16'hFFFF, 16'h0, 16'h0020, 4'h0);
        send_request(eis_pkg::OP_ASH, 16'h1234, 16'h0, 16'hFFDF, 4'h1);
        send_request(eis_pkg::OP_ASHC, 16'h8000, 16'h0001, 16'h001F, 4'h0);
        send_request(eis_pkg::OP_ASHC, 16'h8000, 16'h0000, 16'h0020, 4'h0);
        send_request(eis_pkg::OP_ASHC, 16'h0000, 16'h0000, 16'h0000, 4'h3);
        send_request(eis_pkg::OP_ASHC, 16'hFFFF, 16'hFFFF, 16'h0021, 4'h0);
        send_request(eis_pkg::OP_MUL, 16'h8000, 16'h0, 16'h8000, 4'hF);
        send_request(eis_pkg::OP_MUL, 16'h7FFF, 16'h0, 16'h8000, 4'h0);
        send_request(eis_pkg::OP_MUL, 16'h0000, 16'h0, 16'hFFFF, 4'hF);
        send_request(eis_pkg::OP_DIV, 16'h1234, 16'h5678, 16'h0000, 4'h8);
        send_request(eis_pkg::OP_DIV, 16'h8000, 16'h0000, 16'hFFFF, 4'h0);
        send_request(eis_pkg::OP_DIV, 16'hFFFF, 16'hFFF9, 16'h0002, 4'h0);
        send_request(eis_pkg::OP_DIV, 16'h0000, 16'h0007, 16'hFFFE, 4'h0);
        send_request(eis_pkg::OP_DIV, 16'h7FFF, 16'hFFFF, 16'h7FFF, 4'h0);
        send_request(eis_pkg::OP_DIV, 16'h0000, 16'h0001, 16'h0002, 4'hF);
        send_request(eis_pkg::OP_XOR, 16'hFFFF, 16'h0, 16'hFFFF, 4'hF);
        send_request(eis_pkg::OP_XOR, 16'h0000, 16'h0, 16'h8000, 4'h3);
        send_request(3'd5, 16'hFFFF, 16'hFFFF, 16'hFFFF, 4'hA);
        send_request(3'd7, 16'h0, 16'h0, 16'h0, 4'h5);

        // sender pauses until everything has drained
        while (pending_count != 0) @(negedge aclk);

        // receiver holds off while requests keep coming
        long_hold <= 1'b1;
        fork
            begin
                repeat (300) @(negedge aclk);
                long_hold <= 1'b0;
            end
            repeat (8) send_random();
        join

        // random bursts with gaps
        while (sent < 1150) begin
            burst = $urandom_range(1, 20);
            repeat (burst) send_random();
            if ($urandom_range(0, 2) != 0)
                repeat ($urandom_range(1, 40)) @(negedge aclk);
        end

        stim_done <= 1'b1;
        while (pending_count != 0) @(negedge aclk);
        repeat (50) @(negedge aclk);
        $display("run covered %0d requests and %0d results over all ops", sent, result_count);
        if (fail_count == 0 && pending_count == 0)
            $display("[eis_shift_multiply_divide_unit_core] OK");
        else
            $display("[eis_shift_multiply_divide_unit_core] ERROR");
        $finish;
    end
endmodule
